FILE: sv/go_to_goal_p_controller_defines.svh
// Assertion macros for the go-to-goal controller.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef GO_TO_GOAL_P_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_P_CONTROLLER_DEFINES_SVH

// Implication checked in the same cycle.
`define G2G_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked a fixed number of cycles later.
`define G2G_ASSERT_DELAY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

FILE: sv/g2g_pkg.sv
// Shared types, widths and constants of the go-to-goal controller.
// No dependencies; imported by the top level.
package g2g_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int CORDIC_STAGES_MAX = 24;
	localparam int HEAD_WIDTH = 16;
	localparam int GUARD_BITS = 8;
	localparam int LIN_WIDTH = 20;
	localparam int ANG_WIDTH = 20;
	localparam int GAIN_WIDTH = 12;
	localparam int TOL_WIDTH = 16;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_WIDTH = 5;

	localparam int DX_W = COORD_WIDTH + 1;
	localparam int CX_W = DX_W + GUARD_BITS + 3;
	localparam int ZW = 35;
	localparam int ERR_W = ZW + 1;
	localparam int DIST_W = COORD_WIDTH + 2;
	localparam int INV_W = 20;
	localparam int PD_W = CX_W + INV_W + 1;
	localparam int AP_W = ERR_W + GAIN_WIDTH + 1;
	localparam int LP_W = GAIN_WIDTH + DIST_W;
	localparam int DIST_SHIFT = GUARD_BITS + INV_W;
	localparam int LIN_SHIFT = 8;
	localparam int ANG_SHIFT = 25;
	localparam int HEAD_SHIFT = 17;

	localparam logic [INV_W-1:0] INV_GAIN_Q20 = 20'd636751;
	localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

	localparam logic [ZW-1:0] ATAN_Q30 [CORDIC_STAGES_MAX] = '{
		35'd843314856, 35'd497837829, 35'd263043836, 35'd133525158,
		35'd67021686, 35'd33543515, 35'd16775850, 35'd8388437,
		35'd4194282, 35'd2097149, 35'd1048575, 35'd524287,
		35'd262143, 35'd131071, 35'd65535, 35'd32767,
		35'd16383, 35'd8191, 35'd4095, 35'd2047,
		35'd1023, 35'd511, 35'd255, 35'd127
	};

	typedef enum logic [2:0] {
		REG_GOAL_X = 3'd0,
		REG_GOAL_Y = 3'd1,
		REG_TOLERANCE = 3'd2,
		REG_LIN_GAIN = 3'd3,
		REG_ANG_GAIN = 3'd4
	} g2g_reg_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] pose_x;
		logic signed [COORD_WIDTH-1:0] pose_y;
		logic signed [HEAD_WIDTH-1:0] pose_heading;
	} g2g_request_t;

	typedef struct packed {
		logic [LIN_WIDTH-1:0] linear_velocity;
		logic signed [ANG_WIDTH-1:0] angular_velocity;
		logic arrived;
	} g2g_result_t;

endpackage

FILE: sv/go_to_goal_p_controller.sv
// Top level of the proportional go-to-goal controller: register file, pipelined
// CORDIC in vectoring mode, gain multipliers and saturation.
// Depends on g2g_pkg and go_to_goal_p_controller_defines.svh.
//
// Usage: a pose request is taken at each rising edge with start high; busy is
// always low, so a new request may follow in every cycle. Each request gives
// exactly one result, shown on result for one cycle with done high, in the
// same order as the requests.
// The pipeline holds one entry stage forming the goal offset, one stage per
// CORDIC iteration, then four stages for gain removal, the two
// multiplications, rounding and saturation. Throughput is one request per
// cycle, set by the fully pipelined CORDIC and multipliers.
// The receiver cannot hold results off, so no back-pressure exists anywhere.
// Configuration goes through the APB port, register i at byte address 4*i;
// pready is always high and a write lands at the access cycle. Writes should
// be made while no request is in flight.
// Reset clears all in-flight requests and loads the default goal, tolerance
// and gains.
`include "go_to_goal_p_controller_defines.svh"

module go_to_goal_p_controller
	import g2g_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  g2g_request_t request,
	output logic done,
	output g2g_result_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [DATA_WIDTH-1:0] pwdata,
	output logic [DATA_WIDTH-1:0] prdata,
	output logic pready
);

	localparam int LAT = CORDIC_STAGES + 5;

	logic signed [COORD_WIDTH-1:0] goal_x_q, goal_y_q;
	logic [TOL_WIDTH-1:0] tol_q;
	logic [GAIN_WIDTH-1:0] lin_gain_q, ang_gain_q;

	g2g_reg_t reg_sel;
	logic cfg_wr;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign reg_sel = g2g_reg_t'(paddr[ADDR_WIDTH-1:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q <= COORD_WIDTH'(2048);
			goal_y_q <= COORD_WIDTH'(2048);
			tol_q <= TOL_WIDTH'(20);
			lin_gain_q <= GAIN_WIDTH'(384);
			ang_gain_q <= GAIN_WIDTH'(1024);
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_GOAL_X: goal_x_q <= pwdata[COORD_WIDTH-1:0];
				REG_GOAL_Y: goal_y_q <= pwdata[COORD_WIDTH-1:0];
				REG_TOLERANCE: tol_q <= pwdata[TOL_WIDTH-1:0];
				REG_LIN_GAIN: lin_gain_q <= pwdata[GAIN_WIDTH-1:0];
				REG_ANG_GAIN: ang_gain_q <= pwdata[GAIN_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_GOAL_X: prdata = DATA_WIDTH'($unsigned(goal_x_q));
			REG_GOAL_Y: prdata = DATA_WIDTH'($unsigned(goal_y_q));
			REG_TOLERANCE: prdata = DATA_WIDTH'(tol_q);
			REG_LIN_GAIN: prdata = DATA_WIDTH'(lin_gain_q);
			REG_ANG_GAIN: prdata = DATA_WIDTH'(ang_gain_q);
			default: prdata = '0;
		endcase
	end

	// Entry stage: goal offset with guard bits, pre-rotated by pi when the goal
	// lies behind the pose.
	logic signed [DX_W-1:0] dx, dy;
	logic signed [CX_W-1:0] x0, y0;

	assign dx = DX_W'(goal_x_q) - DX_W'(request.pose_x);
	assign dy = DX_W'(goal_y_q) - DX_W'(request.pose_y);
	assign x0 = CX_W'(dx) <<< GUARD_BITS;
	assign y0 = CX_W'(dy) <<< GUARD_BITS;

	logic vld_sc [CORDIC_STAGES+1];
	logic signed [CX_W-1:0] x_sc [CORDIC_STAGES+1];
	logic signed [CX_W-1:0] y_sc [CORDIC_STAGES+1];
	logic signed [ZW-1:0] z_sc [CORDIC_STAGES+1];
	logic signed [HEAD_WIDTH-1:0] hd_sc [CORDIC_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sc[0] <= 1'b0;
		end else begin
			vld_sc[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		hd_sc[0] <= request.pose_heading;
		if (x0 < 0) begin
			x_sc[0] <= -x0;
			y_sc[0] <= -y0;
			z_sc[0] <= (y0 >= 0) ? PI_Q30 : -PI_Q30;
		end else begin
			x_sc[0] <= x0;
			y_sc[0] <= y0;
			z_sc[0] <= '0;
		end
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sc[k+1] <= 1'b0;
			end else begin
				vld_sc[k+1] <= vld_sc[k];
			end
		end

		always_ff @(posedge clk) begin
			hd_sc[k+1] <= hd_sc[k];
			if (!y_sc[k][CX_W-1]) begin
				x_sc[k+1] <= x_sc[k] + (y_sc[k] >>> k);
				y_sc[k+1] <= y_sc[k] - (x_sc[k] >>> k);
				z_sc[k+1] <= z_sc[k] + $signed(ATAN_Q30[k]);
			end else begin
				x_sc[k+1] <= x_sc[k] - (y_sc[k] >>> k);
				y_sc[k+1] <= y_sc[k] + (x_sc[k] >>> k);
				z_sc[k+1] <= z_sc[k] - $signed(ATAN_Q30[k]);
			end
		end
	end

	logic vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [PD_W-1:0] dprod_s2;
	logic signed [ERR_W-1:0] err_s2;
	logic [DIST_W-1:0] dist_s3;
	logic signed [AP_W-1:0] aprod_s3;
	logic arrived_s4;
	logic [LP_W-1:0] lprod_s4;
	logic signed [ANG_WIDTH-1:0] ang_s4;
	g2g_result_t res_s5;

	logic signed [PD_W-1:0] dround;
	logic signed [AP_W-1:0] around;
	logic signed [AP_W-ANG_SHIFT-1:0] ang_sh;
	logic [LP_W:0] lround;
	logic [LP_W-LIN_SHIFT:0] lin_sh;
	logic arrived_c;
	logic signed [ANG_WIDTH-1:0] ang_sat;
	logic [LIN_WIDTH-1:0] lin_sat;

	always_comb begin
		dround = dprod_s2 + (PD_W'(1) <<< (DIST_SHIFT - 1));
		around = aprod_s3 + (AP_W'(1) <<< (ANG_SHIFT - 1));
		ang_sh = around[AP_W-1:ANG_SHIFT];
		arrived_c = {{(DIST_W-TOL_WIDTH){1'b0}}, tol_q} >= dist_s3;
		if (ang_sh[AP_W-ANG_SHIFT-1:ANG_WIDTH-1] == '0 ||
			ang_sh[AP_W-ANG_SHIFT-1:ANG_WIDTH-1] == '1) begin
			ang_sat = ang_sh[ANG_WIDTH-1:0];
		end else if (ang_sh[AP_W-ANG_SHIFT-1]) begin
			ang_sat = {1'b1, {(ANG_WIDTH-1){1'b0}}};
		end else begin
			ang_sat = {1'b0, {(ANG_WIDTH-1){1'b1}}};
		end
		lround = (LP_W+1)'(lprod_s4) + (LP_W+1)'(1 << (LIN_SHIFT - 1));
		lin_sh = lround[LP_W:LIN_SHIFT];
		if (|lin_sh[LP_W-LIN_SHIFT:LIN_WIDTH]) begin
			lin_sat = '1;
		end else begin
			lin_sat = lin_sh[LIN_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s2 <= vld_sc[CORDIC_STAGES];
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		dprod_s2 <= x_sc[CORDIC_STAGES] * $signed({1'b0, INV_GAIN_Q20});
		err_s2 <= ERR_W'(z_sc[CORDIC_STAGES]) -
			(ERR_W'(hd_sc[CORDIC_STAGES]) <<< HEAD_SHIFT);
		dist_s3 <= dround[DIST_SHIFT +: DIST_W];
		aprod_s3 <= $signed({1'b0, ang_gain_q}) * err_s2;
		arrived_s4 <= arrived_c;
		lprod_s4 <= LP_W'(lin_gain_q) * LP_W'(dist_s3);
		ang_s4 <= arrived_c ? '0 : ang_sat;
		res_s5.arrived <= arrived_s4;
		res_s5.angular_velocity <= ang_s4;
		res_s5.linear_velocity <= arrived_s4 ? '0 : lin_sat;
	end

	assign done = vld_s5;
	assign result = res_s5;

	`G2G_ASSERT_DELAY(a_latency, start && !busy, LAT, done, "Request produced no result in time.")
	`G2G_ASSERT_IMPL(a_no_stray, done, $past(start && !busy, LAT), "Result without a request.")
	`G2G_ASSERT_IMPL(a_arrived_zero, done && result.arrived, result.linear_velocity == '0 && result.angular_velocity == '0, "Arrived result has nonzero velocity.")

endmodule

FILE: bench/tb_go_to_goal_p_controller.sv
// Self-checking testbench for go_to_goal_p_controller: directed and random pose requests
// under several register settings, with results checked against a built-in predictor.
// Depends on g2g_pkg and the controller RTL only.
module tb_go_to_goal_p_controller
	import g2g_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAGES = CORDIC_STAGES_DEF;
	localparam int LATENCY = STAGES + 5;
	localparam int REG_UNMAPPED = 7;
	localparam int PHASES = 5;
	localparam int PHASE_ITEMS = 380;
	localparam longint PI_Q30_TB = 64'sd3373259426;
	localparam longint INV_CORDIC_GAIN = 64'sd636751;
	localparam longint LIN_LIMIT = 64'sd1048575;
	localparam longint ANG_HIGH = 64'sd524287;
	localparam longint ANG_LOW = -64'sd524288;
	localparam longint ARCTAN_Q30 [16] = '{
		843314856, 497837829, 263043836, 133525158,
		67021686, 33543515, 16775850, 8388437,
		4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767
	};

	class velocity_scoreboard;
		g2g_result_t command_q[$];
		logic signed [15:0] goal_x;
		logic signed [15:0] goal_y;
		logic [15:0] tolerance;
		logic [11:0] lin_gain;
		logic [11:0] ang_gain;
		int bad_commands;

		function new();
			goal_x = 16'sd2048;
			goal_y = 16'sd2048;
			tolerance = 16'd20;
			lin_gain = 12'd384;
			ang_gain = 12'd1024;
			bad_commands = 0;
		endfunction

		function void set_register(input int idx, input logic [31:0] value);
			case (idx)
				REG_GOAL_X: goal_x = value[15:0];
				REG_GOAL_Y: goal_y = value[15:0];
				REG_TOLERANCE: tolerance = value[15:0];
				REG_LIN_GAIN: lin_gain = value[11:0];
				REG_ANG_GAIN: ang_gain = value[11:0];
				default: ;
			endcase
		endfunction

		function g2g_result_t steer(input g2g_request_t req);
			longint x, y, z, xs, ys, distance, err, lin, ang;
			g2g_result_t cmd;
			int i;
			x = (longint'(goal_x) - longint'($signed(req.pose_x))) * 256;
			y = (longint'(goal_y) - longint'($signed(req.pose_y))) * 256;
			z = 0;
			// A goal behind the pose is turned around by pi before the iterations.
			if (x < 0) begin
				z = (y >= 0) ? PI_Q30_TB : -PI_Q30_TB;
				x = -x;
				y = -y;
			end
			for (i = 0; i < STAGES; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + ARCTAN_Q30[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - ARCTAN_Q30[i];
				end
			end
			distance = (x * INV_CORDIC_GAIN + (longint'(1) << 27)) >>> 28;
			cmd.arrived = (distance <= longint'(tolerance));
			lin = 0;
			ang = 0;
			if (!cmd.arrived) begin
				err = z - longint'($signed(req.pose_heading)) * 131072;
				lin = (longint'(lin_gain) * distance + 128) >>> 8;
				ang = (longint'(ang_gain) * err + (longint'(1) << 24)) >>> 25;
				lin = (lin > LIN_LIMIT) ? LIN_LIMIT : ((lin < 0) ? 0 : lin);
				ang = (ang > ANG_HIGH) ? ANG_HIGH : ((ang < ANG_LOW) ? ANG_LOW : ang);
			end
			cmd.linear_velocity = lin[19:0];
			cmd.angular_velocity = ang[19:0];
			return cmd;
		endfunction

		function void note_pose(input g2g_request_t req);
			command_q.push_back(steer(req));
		endfunction

		function void report(input string what, input g2g_result_t want, input g2g_result_t got);
			bad_commands++;
			if (bad_commands <= 10) begin
				$display("%s: expected lin %0d ang %0d arrived %0d, got lin %0d ang %0d arrived %0d",
					what, want.linear_velocity, want.angular_velocity, want.arrived,
					got.linear_velocity, got.angular_velocity, got.arrived);
			end
		endfunction

		function void check_command(input g2g_result_t got);
			g2g_result_t want;
			if (command_q.size() == 0) begin
				report("unexpected result", '0, got);
				return;
			end
			want = command_q.pop_front();
			if (got.linear_velocity !== want.linear_velocity
					|| got.angular_velocity !== want.angular_velocity
					|| got.arrived !== want.arrived) begin
				report("velocity mismatch", want, got);
			end
		endfunction

		function int outstanding();
			return command_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	g2g_request_t request = '0;
	logic done;
	g2g_result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_WIDTH-1:0] paddr = '0;
	logic [DATA_WIDTH-1:0] pwdata = '0;
	logic [DATA_WIDTH-1:0] prdata;
	logic pready;

	velocity_scoreboard sb = new();

	go_to_goal_p_controller #(
		.CORDIC_STAGES(STAGES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_command(result);
		end
	end

	function automatic logic [15:0] clamp16(input int v);
		return 16'((v > 32767) ? 32767 : ((v < -32768) ? -32768 : v));
	endfunction

	function automatic g2g_request_t random_pose(input int near_pct);
		g2g_request_t req;
		req.pose_x = 16'($urandom);
		req.pose_y = 16'($urandom);
		req.pose_heading = 16'($urandom);
		if ($urandom_range(99) < near_pct) begin
			req.pose_x = clamp16(int'(sb.goal_x) + int'($urandom_range(96)) - 48);
			req.pose_y = clamp16(int'(sb.goal_y) + int'($urandom_range(96)) - 48);
		end
		if ($urandom_range(99) < 85) begin
			req.pose_heading = 16'(int'($urandom_range(51472)) - 25736);
		end
		return req;
	endfunction

	task automatic write_reg(input int idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_WIDTH'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_register(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int gx, input int gy, input int tol, input int lg,
			input int ag);
		write_reg(REG_GOAL_X, {16'h0, 16'(gx)});
		write_reg(REG_GOAL_Y, {16'h0, 16'(gy)});
		write_reg(REG_TOLERANCE, {16'h0, 16'(tol)});
		write_reg(REG_LIN_GAIN, {20'h0, 12'(lg)});
		write_reg(REG_ANG_GAIN, {20'h0, 12'(ag)});
	endtask

	task automatic send_pose(input g2g_request_t req);
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_pose(req);
	endtask

	task automatic drain();
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic run_directed();
		int poses [16][3] = '{
			'{2048, 2048, 0}, '{2068, 2048, 0}, '{2069, 2048, 0},
			'{-32768, -32768, 25736}, '{32767, 32767, -25736},
			'{-32768, 32767, 32767}, '{32767, -32768, -32768},
			'{4096, 2048, 0}, '{4096, 4096, 1000}, '{4096, 0, -1000},
			'{0, 2048, 0}, '{2048, 0, 0}, '{2048, 4096, 0},
			'{-1, -1, -1}, '{0, 0, 0}, '{2047, 2049, 25736}
		};
		g2g_request_t req;
		foreach (poses[n]) begin
			req.pose_x = 16'(poses[n][0]);
			req.pose_y = 16'(poses[n][1]);
			req.pose_heading = 16'(poses[n][2]);
			send_pose(req);
		end
		start <= 1'b0;
	endtask

	task automatic run_random(input int idle_pct, input int count, input bit pause);
		int gap;
		for (int n = 0; n < count; n++) begin
			send_pose(random_pose(30));
			gap = 0;
			while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
			if (gap > 0 || n == count - 1 || (pause && n == count / 2)) begin
				start <= 1'b0;
			end
			repeat (gap) @(posedge clk);
			// Let the pipeline empty completely once before continuing.
			if (pause && n == count / 2) begin
				drain();
			end
		end
	endtask

	initial begin
		int idle_pcts [PHASES] = '{0, 61, 0, 15, 61};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: configure(0, 0, 0, 4095, 4095);
				1: configure(32767, -32768, 65535, 0, 0);
				2: configure(-32768, 32767, $urandom_range(64), $urandom_range(4095),
					$urandom_range(4095));
				default: begin
					configure($urandom_range(65535), $urandom_range(65535),
						($urandom_range(1)) ? $urandom_range(512) : $urandom_range(65535),
						$urandom_range(4095), $urandom_range(4095));
					write_reg(REG_UNMAPPED, $urandom);
				end
			endcase
			run_random(idle_pcts[p], PHASE_ITEMS, p == 2);
		end
		drain();
		if (sb.bad_commands == 0) begin
			$display("go_to_goal_p_controller verification clean");
		end else begin
			$display("go_to_goal_p_controller verification failed");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("go_to_goal_p_controller verification failed");
		$finish;
	end

endmodule
